FILE: rtl/lfe_pkg.sv
// Shared types and constants for the Life row-generation block.
// No dependencies; imported by the cell, the result queue and the top level.
package lfe_pkg;

  // Grid geometry and field widths
  localparam int GRID_COLS   = 32;
  localparam int ROW_IDX_W   = 10;
  localparam int CFG_W       = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0] RESET_ROW_WIDTH = 6'd30;

  // One column's view of the three rows, passed between neighbouring cells
  typedef struct packed {
    logic older;
    logic newer;
    logic cur;
  } lfe_nbr_t;

  // One result word
  typedef struct packed {
    logic [GRID_COLS-1:0] next_row;
    logic [ROW_IDX_W-1:0] out_row;
    logic                 frame_end;
  } lfe_result_t;

endpackage

FILE: rtl/lfe_cell.sv
// One column cell: holds the two stored rows for its column and works out
// the next-generation bit from its own and its neighbours' bits. Uses lfe_pkg.
module lfe_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              col_en,
  input  logic              cur_in,
  input  logic              load,
  input  logic              last,
  input  lfe_pkg::lfe_nbr_t left,
  input  lfe_pkg::lfe_nbr_t right,
  output lfe_pkg::lfe_nbr_t own,
  output logic              gen_a,
  output logic              gen_b
);
  import lfe_pkg::*;

  logic older_r, older_nxt;
  logic newer_r, newer_nxt;

  // B3/S23 rule on eight neighbours and the centre
  function automatic logic life_rule(input logic [7:0] nb, input logic self);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'd0, nb[k]};
    end
    return (n == 4'd3) || (self && (n == 4'd2));
  endfunction

  // Masked bits seen by this cell and its neighbours
  assign own.older = older_r & col_en;
  assign own.newer = newer_r & col_en;
  assign own.cur   = cur_in & col_en;

  // Row above is older, centre is newer, below is the incoming row
  assign gen_a = col_en & life_rule({left.older, own.older, right.older,
                                     left.newer, right.newer,
                                     left.cur, own.cur, right.cur}, own.newer);

  // Closing row of the grid: centre is the incoming row, nothing below
  assign gen_b = col_en & life_rule({left.newer, own.newer, right.newer,
                                     left.cur, right.cur,
                                     3'b000}, own.cur);

  // Shift the rows down on each word; the last word clears the grid
  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    if (load) begin
      older_nxt = last ? 1'b0 : newer_r;
      newer_nxt = last ? 1'b0 : own.cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= 1'b0;
      newer_r <= 1'b0;
    end else begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
    end
  end

endmodule

FILE: rtl/lfe_out_queue.sv
// Small result queue: takes up to two words per cycle, hands out one unless out_stall is high.
// Uses lfe_pkg for the result word type and depth.
module lfe_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_first,
  input  logic                 push_second,
  input  lfe_pkg::lfe_result_t word0,
  input  lfe_pkg::lfe_result_t word1,
  input  logic                 out_stall,
  output logic                 out_valid,
  output lfe_pkg::lfe_result_t head,
  output logic                 almost_full
);
  import lfe_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lfe_result_t q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] push_n;
  logic             pop;

  assign out_valid   = (count_r != '0);
  assign head        = q_r[rd_ptr_r];
  assign pop         = out_valid && !out_stall;
  // Room for two more words is needed before a new input word goes in
  assign almost_full = (count_r > CNT_W'(QUEUE_DEPTH - 2));

  // Pointer and count update
  always_comb begin
    push_n     = CNT_W'(push_first) + CNT_W'(push_second);
    count_nxt  = count_r + push_n - CNT_W'(pop);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push_first) begin
      q_r[wr_ptr_r] <= word0;
    end
    if (push_second) begin
      q_r[wr_ptr_r + PTR_W'(1)] <= word1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push_second |-> push_first)
    else $error("second word pushed alone");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (PTR_W'(wr_ptr_r - rd_ptr_r) == count_r[PTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule

FILE: rtl/life_generation_rows_core.sv
// Life (B3/S23) next generation over a grid streamed one row per word.
// Throughput: one row word per cycle while in_stall is low; the last row of a
// grid of two or more rows gives two words, held in a four-word result queue,
// and in_stall rises when it holds three or more.
// Reset (synchronous, rst_n low) clears stored rows, row count and queue,
// and sets row_width to 30. Uses lfe_pkg, lfe_cell and lfe_out_queue.
module life_generation_rows_core #(
  parameter int MAX_WIDTH = 32,
  parameter int MAX_ROWS  = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // row words in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lfe_pkg::GRID_COLS-1:0] in_row_bits,
  input  logic                          in_last_row,
  // result words out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lfe_pkg::GRID_COLS-1:0] out_next_row,
  output logic [lfe_pkg::ROW_IDX_W-1:0] out_row,
  output logic                          out_frame_end,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfe_pkg::CFG_W-1:0]     cfg_row_width
);
  import lfe_pkg::*;

  localparam int WIDTH_CAP = (MAX_WIDTH < GRID_COLS) ? MAX_WIDTH : GRID_COLS;
  localparam int ROW_CAP   = (MAX_ROWS - 1 > 1023) ? 1023 : MAX_ROWS - 1;

  logic [CFG_W-1:0]     row_width_r;
  logic [CFG_W-1:0]     eff_width;
  logic                 held_r, held_nxt;
  logic [ROW_IDX_W-1:0] row_count_r, row_count_nxt, count_inc;
  logic                 acc;
  logic                 almost_full;
  logic                 push_first, push_second;
  lfe_result_t          word0, word1, head;

  logic [GRID_COLS-1:0] col_en;
  logic [GRID_COLS-1:0] gen_a, gen_b;
  lfe_nbr_t             nbr [GRID_COLS];

  // Configuration register, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= RESET_ROW_WIDTH;
    end else if (cfg_valid) begin
      row_width_r <= cfg_row_width;
    end
  end

  // Column enables from the capped width
  assign eff_width = (row_width_r > CFG_W'(WIDTH_CAP)) ? CFG_W'(WIDTH_CAP) : row_width_r;
  always_comb begin
    for (int j = 0; j < GRID_COLS; j++) begin
      col_en[j] = (CFG_W'(j) < eff_width);
    end
  end

  assign in_stall = almost_full;
  assign acc      = in_valid && !in_stall;

  // Chain of column cells, each sees its left and right neighbour
  for (genvar j = 0; j < GRID_COLS; j++) begin : g_col
    lfe_nbr_t left_nb, right_nb;
    if (j == 0) begin : g_lo
      assign left_nb = '0;
    end else begin : g_lo_n
      assign left_nb = nbr[j-1];
    end
    if (j == GRID_COLS - 1) begin : g_hi
      assign right_nb = '0;
    end else begin : g_hi_n
      assign right_nb = nbr[j+1];
    end
    lfe_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .col_en (col_en[j]),
      .cur_in (in_row_bits[j]),
      .load   (acc),
      .last   (in_last_row),
      .left   (left_nb),
      .right  (right_nb),
      .own    (nbr[j]),
      .gen_a  (gen_a[j]),
      .gen_b  (gen_b[j])
    );
  end

  // Row sequencing and result words
  always_comb begin
    count_inc     = (row_count_r < ROW_IDX_W'(ROW_CAP)) ? row_count_r + 1'b1 : row_count_r;
    held_nxt      = held_r;
    row_count_nxt = row_count_r;
    push_first    = 1'b0;
    push_second   = 1'b0;
    word0         = '{next_row: gen_a, out_row: row_count_r, frame_end: 1'b0};
    word1         = '{next_row: gen_b, out_row: count_inc, frame_end: 1'b1};
    if (acc) begin
      if (!held_r) begin
        // first row of a grid: a single-row grid closes at once
        word0 = '{next_row: gen_b, out_row: '0, frame_end: 1'b1};
        push_first = in_last_row;
        held_nxt   = !in_last_row;
      end else begin
        push_first    = 1'b1;
        push_second   = in_last_row;
        row_count_nxt = in_last_row ? '0 : count_inc;
        held_nxt      = !in_last_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      row_count_r <= '0;
    end else begin
      held_r      <= held_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  lfe_out_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_first  (push_first),
    .push_second (push_second),
    .word0       (word0),
    .word1       (word1),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .head        (head),
    .almost_full (almost_full)
  );

  assign out_next_row  = head.next_row;
  assign out_row       = head.out_row;
  assign out_frame_end = head.frame_end;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last_row) |=> (!held_r && (row_count_r == '0)))
    else $error("grid state not cleared after last row");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= ROW_IDX_W'(ROW_CAP))
    else $error("row count beyond cap");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (row_count_r == '0))
    else $error("row count set with no row held");

endmodule
